/* rtl/core/carg_pkg.sv */
// Shared types and constants for the cell array rectangle generator.
// No dependencies; every core module takes names from here by scope.
package carg_pkg;

  localparam int COORD_BITS = 16;
  localparam int COUNT_BITS = 12;
  localparam int OUT_W      = COORD_BITS + 1;
  localparam int CELLS_W    = COUNT_BITS + 1;
  localparam int DIVD_W     = COORD_BITS + 2;
  localparam int REM_W      = CELLS_W + 1;
  localparam int QCNT_W     = $clog2(OUT_W + 1);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COORD_BITS;

  localparam logic [CELLS_W-1:0] CELL_MAX = CELLS_W'(1) << COUNT_BITS;
  localparam logic [OUT_W-1:0]   OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_P_X          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_P_Y          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_Q_X          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Q_Y          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_R_X          = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_R_Y          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_FIRST  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CELLS_SECOND = 3'd7;

  typedef enum logic [1:0] {
    MODE_HRECT = 2'd0,
    MODE_VRECT = 2'd1,
    MODE_PARA  = 2'd2
  } mode_t;

  // One divide job per step value
  typedef enum logic [1:0] {
    JOB_FIRST_X  = 2'd0,
    JOB_FIRST_Y  = 2'd1,
    JOB_SECOND_X = 2'd2,
    JOB_SECOND_Y = 2'd3
  } job_t;

  typedef struct packed {
    logic take;
    logic div_start;
    logic div_store;
    job_t job;
    logic finalize;
    logic emit;
    logic emit_latched;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic out_space;
    logic last;
  } stat_t;

endpackage

/* rtl/core/cell_array_rect_generator.sv */
// Top level of the cell array rectangle generator.
// Depends on carg_pkg, carg_ctrl, carg_dp (which holds carg_div).
//
// Usage:
//   Write corners P, Q, R and the two cell counts over the cfg channel
//   (cfg_valid/cfg_ready, cfg_index, cfg_data) while the block is idle.
//   cfg_ready is always high. Any write restarts the array.
//   Stream colour indices in array order on cell_color (in_valid/in_stall);
//   each transfer yields one cell result on the output channel
//   (out_valid/out_stall): shape_kind, corners or origin and size,
//   color_out, too_small and last_cell.
// Setup and streaming:
//   The first cell of an array runs the setup: four step divisions on one
//   bit-serial divider, then a finalize state and an emit state.
//   Every further cell of that array is a cursor add: one transfer per
//   cycle while in_stall is low, its result registered in the next cycle.
//   After last_cell the next transfer runs the setup again.
// Stall:
//   The result sits in an output register. While the receiver stalls and
//   that register is full, in_stall holds mid-array cells off; a cell that
//   starts an array is still taken and its setup runs behind the stall.
// Reset:
//   rst (synchronous) restores P, Q, R to zero and both counts to one,
//   drops any pending result, and forces setup on the next transfer.
module cell_array_rect_generator (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [carg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [carg_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            cell_color,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  shape_kind,
  output logic signed [carg_pkg::OUT_W-1:0]     x0,
  output logic signed [carg_pkg::OUT_W-1:0]     y0,
  output logic signed [carg_pkg::OUT_W-1:0]     x1,
  output logic signed [carg_pkg::OUT_W-1:0]     y1,
  output logic signed [carg_pkg::OUT_W-1:0]     x2,
  output logic signed [carg_pkg::OUT_W-1:0]     y2,
  output logic signed [carg_pkg::OUT_W-1:0]     x3,
  output logic signed [carg_pkg::OUT_W-1:0]     y3,
  output logic [7:0]                            color_out,
  output logic                                  too_small,
  output logic                                  last_cell
);

  carg_pkg::cmd_t  cmd;
  carg_pkg::stat_t stat;
  logic            cfg_we;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  // Sequence setup, accept colours, decide when to emit
  carg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Hold config, divide the steps, walk the cursor, drive the result
  carg_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cell_color (cell_color),
    .out_stall  (out_stall),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (out_valid),
    .shape_kind (shape_kind),
    .x0         (x0),
    .y0         (y0),
    .x1         (x1),
    .y1         (y1),
    .x2         (x2),
    .y2         (y2),
    .x3         (x3),
    .y3         (y3),
    .color_out  (color_out),
    .too_small  (too_small),
    .last_cell  (last_cell)
  );

endmodule

/* rtl/core/carg_div.sv */
// Bit-serial signed divider, truncating toward zero, saturating result.
// Depends on carg_pkg for widths.
module carg_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [carg_pkg::DIVD_W-1:0]  dividend,
  input  logic        [carg_pkg::CELLS_W-1:0] divisor,
  output logic                                busy,
  output logic                                done,
  output logic signed [carg_pkg::OUT_W-1:0]   quot
);

  logic                              neg;
  logic [carg_pkg::QCNT_W-1:0]       cnt;
  logic [carg_pkg::REM_W-1:0]        rem;
  logic [carg_pkg::OUT_W-1:0]        qsh;
  logic [carg_pkg::CELLS_W-1:0]      dvs;
  logic [carg_pkg::DIVD_W-1:0]       mag;
  logic [carg_pkg::REM_W-1:0]        trial;
  logic                              fits;

  assign mag   = dividend[carg_pkg::DIVD_W-1] ? -dividend : dividend;
  assign trial = {rem[carg_pkg::REM_W-2:0], qsh[carg_pkg::OUT_W-1]};
  assign fits  = trial >= carg_pkg::REM_W'(dvs);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= carg_pkg::QCNT_W'(carg_pkg::OUT_W);
        neg  <= dividend[carg_pkg::DIVD_W-1];
        qsh  <= mag[carg_pkg::OUT_W-1:0];
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        // one quotient bit per cycle
        rem <= fits ? trial - carg_pkg::REM_W'(dvs) : trial;
        qsh <= {qsh[carg_pkg::OUT_W-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == carg_pkg::QCNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // +2^COORD_BITS only fits on the negative side: clamp the positive one
  assign quot = neg ? -qsh : (qsh[carg_pkg::OUT_W-1] ? carg_pkg::OUT_MAX : qsh);

endmodule

/* rtl/core/carg_ctrl.sv */
// Controller: array setup sequencing, input handshake and cell emission.
// Depends on carg_pkg for the command and status structs.
module carg_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            cfg_we,
  input  carg_pkg::stat_t stat,
  output carg_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t         state, state_next;
  carg_pkg::job_t job, job_next;
  logic           setup_done, setup_done_next;
  logic           accept;

  assign in_stall = !(state == ST_IDLE && (!setup_done || stat.out_space));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next      = state;
    job_next        = job;
    setup_done_next = setup_done;
    cmd             = '0;
    cmd.job         = job;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.take = 1'b1;
          if (setup_done) begin
            cmd.emit = 1'b1;
            if (stat.last) setup_done_next = 1'b0;
          end else begin
            state_next = ST_DIV;
            job_next   = carg_pkg::JOB_FIRST_X;
          end
        end
      end
      ST_DIV: begin
        cmd.div_start = !stat.div_busy && !stat.div_done;
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          case (job)
            carg_pkg::JOB_FIRST_X:  job_next = carg_pkg::JOB_FIRST_Y;
            carg_pkg::JOB_FIRST_Y:  job_next = carg_pkg::JOB_SECOND_X;
            carg_pkg::JOB_SECOND_X: job_next = carg_pkg::JOB_SECOND_Y;
            default:                state_next = ST_FIN;
          endcase
        end
      end
      ST_FIN: begin
        cmd.finalize    = 1'b1;
        setup_done_next = 1'b1;
        state_next      = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_space) begin
          cmd.emit         = 1'b1;
          cmd.emit_latched = 1'b1;
          if (stat.last) setup_done_next = 1'b0;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // any register write restarts the array
    if (cfg_we) setup_done_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      job        <= carg_pkg::JOB_FIRST_X;
      setup_done <= 1'b0;
    end else begin
      state      <= state_next;
      job        <= job_next;
      setup_done <= setup_done_next;
    end
  end

  a_emit_has_space: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_space)
    else $error("cell emitted while output register full");

  a_setup_starts_div: assert property (@(posedge clk) disable iff (rst)
    (accept && !setup_done) |=> state == ST_DIV)
    else $error("array setup did not start");

  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> in_stall)
    else $error("input taken while setup in progress");

  a_last_clears_setup: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.last) |=> !setup_done)
    else $error("setup kept after last cell");

endmodule

/* rtl/core/carg_dp.sv */
// Datapath: config registers, step divider, cursor walk and output register.
// Depends on carg_pkg and carg_div.
module carg_dp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_we,
  input  logic [carg_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [carg_pkg::CFG_DATA_W-1:0]        cfg_data,
  input  logic [7:0]                             cell_color,
  input  logic                                   out_stall,
  input  carg_pkg::cmd_t                         cmd,
  output carg_pkg::stat_t                        stat,
  output logic                                   out_valid,
  output logic                                   shape_kind,
  output logic signed [carg_pkg::OUT_W-1:0]      x0,
  output logic signed [carg_pkg::OUT_W-1:0]      y0,
  output logic signed [carg_pkg::OUT_W-1:0]      x1,
  output logic signed [carg_pkg::OUT_W-1:0]      y1,
  output logic signed [carg_pkg::OUT_W-1:0]      x2,
  output logic signed [carg_pkg::OUT_W-1:0]      y2,
  output logic signed [carg_pkg::OUT_W-1:0]      x3,
  output logic signed [carg_pkg::OUT_W-1:0]      y3,
  output logic [7:0]                             color_out,
  output logic                                   too_small,
  output logic                                   last_cell
);

  localparam int OW = carg_pkg::OUT_W;
  localparam int DW = carg_pkg::DIVD_W;
  localparam int CW = carg_pkg::COUNT_BITS;

  logic signed [carg_pkg::COORD_BITS-1:0] p_x, p_y, q_x, q_y, r_x, r_y;
  logic [carg_pkg::CELLS_W-1:0]           cells_first, cells_second;

  carg_pkg::mode_t mode, mode_now;
  logic signed [OW-1:0] sfx, sfy, ssx, ssy;
  logic signed [OW-1:0] rb_x, rb_y, cur_x, cur_y;
  logic [CW-1:0]        inner, outer;
  logic [7:0]           color_q;

  logic [carg_pkg::CELLS_W-1:0] d1, d2;
  logic [CW-1:0]                d1m1, d2m1;

  function automatic logic [carg_pkg::CELLS_W-1:0] clamp_cells(
    input logic [carg_pkg::CELLS_W-1:0] raw);
    if (raw == '0) return carg_pkg::CELLS_W'(1);
    if (raw > carg_pkg::CELL_MAX) return carg_pkg::CELL_MAX;
    return raw;
  endfunction

  // span plus one edge pixel away from zero; zero_up treats a zero span as positive
  function automatic logic signed [DW-1:0] span(
    input logic signed [carg_pkg::COORD_BITS-1:0] a,
    input logic signed [carg_pkg::COORD_BITS-1:0] b,
    input logic zero_up);
    logic signed [DW-1:0] d;
    d = DW'(a) - DW'(b);
    if (d < 0) return d - 1'b1;
    if (d > 0 || zero_up) return d + 1'b1;
    return d;
  endfunction

  function automatic logic signed [OW-1:0] abs_sat(input logic signed [OW-1:0] v);
    logic [OW:0] m;
    m = v[OW-1] ? -{v[OW-1], v} : {v[OW-1], v};
    return m[OW-1] ? carg_pkg::OUT_MAX : m[OW-1:0];
  endfunction

  assign d1   = clamp_cells(cells_first);
  assign d2   = clamp_cells(cells_second);
  assign d1m1 = CW'(d1 - 1'b1);
  assign d2m1 = CW'(d2 - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      p_x          <= '0;
      p_y          <= '0;
      q_x          <= '0;
      q_y          <= '0;
      r_x          <= '0;
      r_y          <= '0;
      cells_first  <= carg_pkg::CELLS_W'(1);
      cells_second <= carg_pkg::CELLS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        carg_pkg::REG_P_X:          p_x <= cfg_data;
        carg_pkg::REG_P_Y:          p_y <= cfg_data;
        carg_pkg::REG_Q_X:          q_x <= cfg_data;
        carg_pkg::REG_Q_Y:          q_y <= cfg_data;
        carg_pkg::REG_R_X:          r_x <= cfg_data;
        carg_pkg::REG_R_Y:          r_y <= cfg_data;
        carg_pkg::REG_CELLS_FIRST:  cells_first  <= cfg_data[carg_pkg::CELLS_W-1:0];
        carg_pkg::REG_CELLS_SECOND: cells_second <= cfg_data[carg_pkg::CELLS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (q_x == r_x && p_y == r_y)      mode_now = carg_pkg::MODE_HRECT;
    else if (p_x == r_x && q_y == r_y) mode_now = carg_pkg::MODE_VRECT;
    else                               mode_now = carg_pkg::MODE_PARA;
  end

  // Divider operand select; unused steps of a rectangle mode divide zero
  logic signed [DW-1:0] div_n;
  logic [carg_pkg::CELLS_W-1:0] div_d;
  logic signed [OW-1:0] div_q;
  logic div_busy, div_done;

  always_comb begin
    div_n = '0;
    div_d = (cmd.job == carg_pkg::JOB_FIRST_X || cmd.job == carg_pkg::JOB_FIRST_Y)
            ? d1 : d2;
    case (mode_now)
      carg_pkg::MODE_HRECT: begin
        if (cmd.job == carg_pkg::JOB_FIRST_X)  div_n = span(q_x, p_x, 1'b1);
        if (cmd.job == carg_pkg::JOB_SECOND_Y) div_n = span(q_y, p_y, 1'b1);
      end
      carg_pkg::MODE_VRECT: begin
        if (cmd.job == carg_pkg::JOB_FIRST_Y)  div_n = span(q_y, p_y, 1'b1);
        if (cmd.job == carg_pkg::JOB_SECOND_X) div_n = span(q_x, p_x, 1'b1);
      end
      default: begin
        case (cmd.job)
          carg_pkg::JOB_FIRST_X:  div_n = span(r_x, p_x, 1'b0);
          carg_pkg::JOB_FIRST_Y:  div_n = span(r_y, p_y, 1'b0);
          carg_pkg::JOB_SECOND_X: div_n = span(q_x, r_x, 1'b0);
          default:                div_n = span(q_y, r_y, 1'b0);
        endcase
      end
    endcase
  end

  carg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_q)
  );

  // Row start, nudged off P on the sides facing away from Q
  logic signed [OW-1:0] px_e, py_e, rb_x_fin, rb_y_fin;
  assign px_e = {p_x[carg_pkg::COORD_BITS-1], p_x};
  assign py_e = {p_y[carg_pkg::COORD_BITS-1], p_y};

  always_comb begin
    rb_x_fin = px_e;
    rb_y_fin = py_e;
    if (q_x < p_x)
      rb_x_fin = (mode_now == carg_pkg::MODE_PARA) ? px_e + 1'b1 : px_e + sfx + ssx + 1'b1;
    if (q_y < p_y)
      rb_y_fin = (mode_now == carg_pkg::MODE_PARA) ? py_e + 1'b1 : py_e + sfy + ssy + 1'b1;
  end

  // Cell geometry from the current cursor
  logic signed [OW-1:0] w, h, g2x, g2y;
  logic last, zero_size;
  assign w         = abs_sat(mode == carg_pkg::MODE_HRECT ? sfx : ssx);
  assign h         = abs_sat(mode == carg_pkg::MODE_HRECT ? ssy : sfy);
  assign g2x       = cur_x + sfx;
  assign g2y       = cur_y + sfy;
  assign zero_size = (mode != carg_pkg::MODE_PARA) && (w == '0 || h == '0);
  assign last      = (inner == d1m1) && (outer == d2m1);

  logic signed [OW-1:0] rb_x_adv, rb_y_adv;
  assign rb_x_adv = rb_x + ssx;
  assign rb_y_adv = rb_y + ssy;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= carg_pkg::MODE_HRECT;
      sfx   <= '0;
      sfy   <= '0;
      ssx   <= '0;
      ssy   <= '0;
      rb_x  <= '0;
      rb_y  <= '0;
      cur_x <= '0;
      cur_y <= '0;
      inner <= '0;
      outer <= '0;
    end else begin
      if (cmd.div_store) begin
        case (cmd.job)
          carg_pkg::JOB_FIRST_X:  sfx <= div_q;
          carg_pkg::JOB_FIRST_Y:  sfy <= div_q;
          carg_pkg::JOB_SECOND_X: ssx <= div_q;
          default:                ssy <= div_q;
        endcase
      end
      if (cmd.finalize) begin
        mode  <= mode_now;
        rb_x  <= rb_x_fin;
        rb_y  <= rb_y_fin;
        cur_x <= rb_x_fin;
        cur_y <= rb_y_fin;
        inner <= '0;
        outer <= '0;
      end else if (cmd.emit && !last) begin
        if (inner != d1m1) begin
          inner <= inner + 1'b1;
          cur_x <= g2x;
          cur_y <= g2y;
        end else begin
          inner <= '0;
          outer <= outer + 1'b1;
          rb_x  <= rb_x_adv;
          rb_y  <= rb_y_adv;
          cur_x <= rb_x_adv;
          cur_y <= rb_y_adv;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) color_q <= cell_color;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      color_out  <= cmd.emit_latched ? color_q : cell_color;
      last_cell  <= last;
      too_small  <= zero_size;
      shape_kind <= (mode == carg_pkg::MODE_PARA);
      if (mode == carg_pkg::MODE_PARA) begin
        x0 <= cur_x;
        y0 <= cur_y;
        x1 <= g2x;
        y1 <= g2y;
        x2 <= g2x + ssx;
        y2 <= g2y + ssy;
        x3 <= cur_x + ssx;
        y3 <= cur_y + ssy;
      end else if (!zero_size) begin
        x0 <= cur_x;
        y0 <= cur_y;
        x1 <= w;
        y1 <= h;
        x2 <= '0; y2 <= '0; x3 <= '0; y3 <= '0;
      end else begin
        x0 <= '0; y0 <= '0; x1 <= '0; y1 <= '0;
        x2 <= '0; y2 <= '0; x3 <= '0; y3 <= '0;
      end
    end
  end

  assign stat.div_busy  = div_busy;
  assign stat.div_done  = div_done;
  assign stat.out_space = !out_valid || !out_stall;
  assign stat.last      = last;

endmodule
